/* rtl/core/cpualu_pkg.sv */
// Shared types, operation codes and flag positions for the CPU ALU.
// Holds the single-pass evaluation function used by the top level.
// No dependencies.
package cpualu_pkg;

  // Operation codes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_ADC   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SBC   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_XOR   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_CP    = 4'd7;
  localparam logic [3:0] OP_INC8  = 4'd8;
  localparam logic [3:0] OP_DEC8  = 4'd9;
  localparam logic [3:0] OP_CPL   = 4'd10;
  localparam logic [3:0] OP_DAA   = 4'd11;
  localparam logic [3:0] OP_ADDHL = 4'd12;
  localparam logic [3:0] OP_ADDSP = 4'd13;
  localparam logic [3:0] OP_INC16 = 4'd14;
  localparam logic [3:0] OP_DEC16 = 4'd15;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  acc_value;
    logic [15:0] operand_value;
    logic [15:0] base_value;
    logic [3:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
  } alu_rsp_t;

  // Evaluate one request: result and updated flags.
  function automatic alu_rsp_t alu_eval(input alu_req_t q);
    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  f;
    logic        cin;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [8:0]  dif8;
    logic [4:0]  dif4;
    logic [7:0]  r8;
    logic        dc;
    logic [7:0]  d1;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [8:0]  sp8;
    logic [4:0]  sp4;
    alu_rsp_t    o;
    a    = q.acc_value;
    v    = q.operand_value[7:0];
    f    = q.flags_in;
    cin  = ((q.req_type == OP_ADC) || (q.req_type == OP_SBC)) && f[FLAG_C];
    sum8 = {1'b0, a} + {1'b0, v} + {8'd0, cin};
    sum4 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
    dif8 = {1'b0, a} - {1'b0, v} - {8'd0, cin};
    dif4 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
    sum16 = {1'b0, q.base_value} + {1'b0, q.operand_value};
    sum12 = {1'b0, q.base_value[11:0]} + {1'b0, q.operand_value[11:0]};
    sp8  = {1'b0, q.base_value[7:0]} + {1'b0, v};
    sp4  = {1'b0, q.base_value[3:0]} + {1'b0, v[3:0]};
    // Decimal adjust, addition side first stage
    dc   = f[FLAG_C] || (a > DAA_HI_LIM);
    d1   = dc ? (a + DAA_HI_ADJ) : a;
    r8   = 8'd0;
    o.result_value = 16'd0;
    o.flags_out    = f;
    case (q.req_type)
      OP_ADD, OP_ADC: begin
        r8 = sum8[7:0];
        o.flags_out[FLAG_H] = sum4[4];
        o.flags_out[FLAG_C] = sum8[8];
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.result_value = {8'd0, r8};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8 = dif8[7:0];
        o.flags_out[FLAG_H] = dif4[4];
        o.flags_out[FLAG_C] = dif8[8];
        o.flags_out[FLAG_N] = 1'b1;
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.result_value = (q.req_type == OP_CP) ? {8'd0, a} : {8'd0, r8};
      end
      OP_AND, OP_XOR, OP_OR: begin
        r8 = (q.req_type == OP_AND) ? (a & v) :
             (q.req_type == OP_XOR) ? (a ^ v) : (a | v);
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_C] = 1'b0;
        o.flags_out[FLAG_H] = (q.req_type == OP_AND);
        o.result_value = {8'd0, r8};
      end
      OP_INC8: begin
        r8 = v + 8'd1;
        o.flags_out[FLAG_H] = (v[3:0] == 4'hF);
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.result_value = {8'd0, r8};
      end
      OP_DEC8: begin
        r8 = v - 8'd1;
        o.flags_out[FLAG_H] = (v[3:0] == 4'h0);
        o.flags_out[FLAG_N] = 1'b1;
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.result_value = {8'd0, r8};
      end
      OP_CPL: begin
        o.result_value = {8'd0, ~a};
        o.flags_out[FLAG_N] = 1'b1;
        o.flags_out[FLAG_H] = 1'b1;
      end
      OP_DAA: begin
        if (!f[FLAG_N]) begin
          r8 = (f[FLAG_H] || (d1[3:0] > DAA_LO_LIM)) ? (d1 + DAA_LO_ADJ) : d1;
          o.flags_out[FLAG_C] = dc;
        end else begin
          r8 = a - (f[FLAG_C] ? DAA_HI_ADJ : 8'd0) - (f[FLAG_H] ? DAA_LO_ADJ : 8'd0);
        end
        o.flags_out[FLAG_Z] = (r8 == 8'd0);
        o.flags_out[FLAG_H] = 1'b0;
        o.result_value = {8'd0, r8};
      end
      OP_ADDHL: begin
        o.result_value = sum16[15:0];
        o.flags_out[FLAG_H] = sum12[12];
        o.flags_out[FLAG_C] = sum16[16];
        o.flags_out[FLAG_N] = 1'b0;
      end
      OP_ADDSP: begin
        o.result_value = q.base_value + {{8{v[7]}}, v};
        o.flags_out[FLAG_Z] = 1'b0;
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_H] = sp4[4];
        o.flags_out[FLAG_C] = sp8[8];
      end
      OP_INC16: o.result_value = q.operand_value + 16'd1;
      OP_DEC16: o.result_value = q.operand_value - 16'd1;
      default:  o.result_value = q.operand_value;
    endcase
    return o;
  endfunction

endpackage

/* rtl/core/cpualu_if.sv */
// Request and response channel interfaces of the CPU ALU.
// Valid/ready handshake; a word moves when both are high at a clock edge.
// No dependencies.
interface cpualu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [7:0]  acc_value;
  logic [15:0] operand_value;
  logic [15:0] base_value;
  logic [3:0]  flags_in;

  modport source (output valid, output req_type, output acc_value,
                  output operand_value, output base_value, output flags_in,
                  input ready);
  modport sink   (input valid, input req_type, input acc_value,
                  input operand_value, input base_value, input flags_in,
                  output ready);
endinterface

interface cpualu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic [3:0]  flags_out;

  modport source (output valid, output result_value, output flags_out, input ready);
  modport sink   (input valid, input result_value, input flags_out, output ready);
endinterface

/* rtl/core/cpu_alu_with_flags.sv */
// CPU ALU top level: 8-bit ALU with flags and 16-bit extras.
// Depends on cpualu_pkg and the interfaces in cpualu_if.sv.
//
// Usage:
//   req carries one operation word: req_type, acc_value, operand_value,
//   base_value and flags_in. rsp returns result_value and flags_out.
//   An accepted word is loaded into the result register, or into the skid
//   register while rsp stalls. Throughput is one word per cycle while rsp
//   takes results, set by the single pass of adder and flag logic.
//   A two-entry output buffer (result register plus skid register) lets a
//   new word be accepted while a finished result waits; req.ready drops
//   only when both entries hold results, i.e. after rsp has stalled with
//   a second word already taken. Results leave in order.
//   Reset (rst, synchronous) empties both entries; req.ready is high in
//   the first cycle after reset. The block holds no architectural state.
module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  cpualu_req_if.sink   req,
  cpualu_rsp_if.source rsp
);

  alu_req_t in_word;
  alu_rsp_t alu_word;
  alu_rsp_t out_word;
  alu_rsp_t skid_word;
  logic     out_valid;
  logic     skid_valid;
  logic     in_take;
  logic     out_free;

  // Gather the request word and evaluate it
  assign in_word = '{req_type:      req.req_type,
                     acc_value:     req.acc_value,
                     operand_value: req.operand_value,
                     base_value:    req.base_value,
                     flags_in:      req.flags_in};
  assign alu_word = alu_eval(in_word);

  // Handshake: accept while the skid entry is free
  assign req.ready = !skid_valid;
  assign in_take   = req.valid && !skid_valid;
  assign out_free  = !out_valid || rsp.ready;

  // Advance the output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_take;
      skid_valid <= 1'b0;
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  // Load result and skid payloads
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_take) begin
        out_word <= alu_word;
      end
    end else if (in_take) begin
      skid_word <= alu_word;
    end
  end

  // Drive the response channel
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_word.result_value;
  assign rsp.flags_out    = out_word.flags_out;

endmodule

/* rtl/core/cpualu_checker.sv */
// Port-level checker for the CPU ALU, bound to cpu_alu_with_flags.
// Depends on cpualu_pkg.
module cpualu_checker
  import cpualu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [3:0]  req_type,
  input logic [7:0]  acc_value,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] result_value,
  input logic [3:0]  flags_out
);

  logic req_take;
  assign req_take = req_valid && req_ready;

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_value) && $stable(flags_out)))
    else $error("stalled response word changed");

  // Drop all results at reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Backpressure only with a result waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request stalled with empty output");

  // An accepted word on an empty output shows in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_take && !rsp_valid) |=> rsp_valid)
    else $error("result missing one cycle after accept");

  // Compare returns the accumulator unchanged
  a_cp_acc: assert property (@(posedge clk) disable iff (rst)
    (req_take && !rsp_valid && (req_type == OP_CP)) |=>
      (result_value == {8'd0, $past(acc_value)}))
    else $error("compare changed the accumulator");

endmodule

bind cpu_alu_with_flags cpualu_checker u_cpualu_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .acc_value    (req.acc_value),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .flags_out    (rsp.flags_out)
);
